/* rtl/core/fqks_pkg.sv */
// shared constants, types and codes for the key-search queue
`default_nettype none

package fqks_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int KEY_W = 31;
  localparam int PAY_W = 32;
  localparam int ACT_W = 2;
  localparam int STS_W = 2;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [PAY_W-1:0] pay_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [ACT_W-1:0] act_t;
  typedef logic [STS_W-1:0] sts_t;

  // action codes
  localparam act_t ACT_ENQ    = 2'd0;
  localparam act_t ACT_DEQ    = 2'd1;
  localparam act_t ACT_SEARCH = 2'd2;

  // status codes
  localparam sts_t STS_DONE     = 2'd0;
  localparam sts_t STS_EMPTY    = 2'd1;
  localparam sts_t STS_FULL     = 2'd2;
  localparam sts_t STS_NOTFOUND = 2'd3;

  // per-cell control from the top level
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

`default_nettype wire

/* rtl/core/fqks_if.sv */
// valid/ready channel interfaces for the key-search queue
`default_nettype none

interface fqks_in_if;
  logic               valid;
  logic               ready;
  fqks_pkg::act_t     action;
  fqks_pkg::key_t     key;
  fqks_pkg::pay_t     payload;

  modport source (output valid, output action, output key, output payload, input ready);
  modport sink   (input valid, input action, input key, input payload, output ready);
endinterface

interface fqks_out_if;
  logic               valid;
  logic               ready;
  fqks_pkg::sts_t     status;
  fqks_pkg::key_t     key_out;
  fqks_pkg::pay_t     payload_out;
  fqks_pkg::cnt_t     occupancy;

  modport source (output valid, output status, output key_out, output payload_out,
                  output occupancy, input ready);
  modport sink   (input valid, input status, input key_out, input payload_out,
                  input occupancy, output ready);
endinterface

`default_nettype wire

/* rtl/core/fqks_cell.sv */
// one queue cell: holds an entry, shifts toward the head, compares its key
`default_nettype none

module fqks_cell (
  input  wire logic                clk,
  input  wire fqks_pkg::cell_ctrl_t ctrl,
  input  wire fqks_pkg::key_t      wr_key,
  input  wire fqks_pkg::pay_t      wr_pay,
  input  wire fqks_pkg::key_t      nb_key,
  input  wire fqks_pkg::pay_t      nb_pay,
  input  wire fqks_pkg::key_t      srch_key,
  output fqks_pkg::key_t           key,
  output fqks_pkg::pay_t           pay,
  output logic                     hit
);
  import fqks_pkg::*;

  key_t key_r, key_nxt;
  pay_t pay_r, pay_nxt;

  // load a new entry or take the neighbor's on a dequeue
  always_comb begin
    key_nxt = key_r;
    pay_nxt = pay_r;
    if (ctrl.load) begin
      key_nxt = wr_key;
      pay_nxt = wr_pay;
    end else if (ctrl.shift) begin
      key_nxt = nb_key;
      pay_nxt = nb_pay;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    pay_r <= pay_nxt;
  end

  assign key = key_r;
  assign pay = pay_r;
  assign hit = (key_r == srch_key);

endmodule

`default_nettype wire

/* rtl/core/fqks_pick.sv */
// priority select of the newest matching cell
`default_nettype none

module fqks_pick (
  input  wire logic [fqks_pkg::DEPTH-1:0] match,
  input  wire fqks_pkg::key_t             keys [fqks_pkg::DEPTH],
  input  wire fqks_pkg::pay_t             pays [fqks_pkg::DEPTH],
  output logic                            found,
  output fqks_pkg::key_t                  key,
  output fqks_pkg::pay_t                  pay
);
  import fqks_pkg::*;

  logic [DEPTH-1:0] above;
  logic [DEPTH-1:0] sel;

  // mark cells that have a match somewhere nearer the rear
  always_comb begin
    above[DEPTH-1] = 1'b0;
    for (int i = DEPTH - 2; i >= 0; i--) begin
      above[i] = above[i+1] | match[i+1];
    end
    sel = match & ~above;
  end

  // one-hot and-or mux
  always_comb begin
    key = '0;
    pay = '0;
    for (int i = 0; i < DEPTH; i++) begin
      key = key | (keys[i] & {KEY_W{sel[i]}});
      pay = pay | (pays[i] & {PAY_W{sel[i]}});
    end
  end

  assign found = |match;

endmodule

`default_nettype wire

/* rtl/core/fifo_queue_with_key_search.sv */
// Bounded FIFO of key/payload entries with a search for the newest entry
// holding a given key. Entries live in a row of cells; cell 0 is the oldest.
// Input channel in_ch carries action, key and payload; output channel out_ch
// returns one transaction per input: status, key_out, payload_out and the
// occupancy after the action.
// Enqueue writes the cell at the current count, dequeue shifts every cell one
// place toward the head, search compares all cells at once and picks the
// matching cell nearest the rear.
// Latency: the result is registered at the edge that accepts the input and
// is valid from the next cycle. Throughput: one transaction per cycle; the
// single output register lets a new input in whenever the previous result is
// taken in the same cycle or none is pending.
// A stall on out_ch holds the result and drops in_ch.ready until the
// result is taken.
// Reset empties the queue (count zero); the cell contents are left as they
// are and are never read before they are written.
`default_nettype none

module fifo_queue_with_key_search (
  input  wire logic  clk,
  input  wire logic  rst_n,
  fqks_in_if.sink    in_ch,
  fqks_out_if.source out_ch
);
  import fqks_pkg::*;

  cnt_t       count_r, count_nxt;
  logic       out_valid_r, out_valid_nxt;
  sts_t       status_r, status_nxt;
  key_t       key_out_r, key_out_nxt;
  pay_t       pay_out_r, pay_out_nxt;
  cnt_t       occ_r;

  logic       acc;
  logic       full, empty;
  logic       enq_ok, deq_ok;
  cell_ctrl_t ctrl [DEPTH];
  key_t       keys [DEPTH];
  pay_t       pays [DEPTH];
  key_t       nb_keys [DEPTH];
  pay_t       nb_pays [DEPTH];
  logic [DEPTH-1:0] hits;
  logic [DEPTH-1:0] match;
  logic       found;
  key_t       found_key;
  pay_t       found_pay;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign acc         = in_ch.valid && in_ch.ready;
  assign full        = (count_r == CNT_W'(DEPTH));
  assign empty       = (count_r == '0);
  assign enq_ok      = acc && (in_ch.action == ACT_ENQ) && !full;
  assign deq_ok      = acc && (in_ch.action == ACT_DEQ) && !empty;

  // cell controls and neighbor links
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ctrl[i].load  = enq_ok && (count_r[IDX_W-1:0] == IDX_W'(i));
      ctrl[i].shift = deq_ok;
      match[i]      = hits[i] && (CNT_W'(i) < count_r);
      if (i == DEPTH - 1) begin
        nb_keys[i] = '0;
        nb_pays[i] = '0;
      end else begin
        nb_keys[i] = keys[i+1];
        nb_pays[i] = pays[i+1];
      end
    end
  end

  // row of cells
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    fqks_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl[g]),
      .wr_key   (in_ch.key),
      .wr_pay   (in_ch.payload),
      .nb_key   (nb_keys[g]),
      .nb_pay   (nb_pays[g]),
      .srch_key (in_ch.key),
      .key      (keys[g]),
      .pay      (pays[g]),
      .hit      (hits[g])
    );
  end

  fqks_pick u_pick (
    .match (match),
    .keys  (keys),
    .pays  (pays),
    .found (found),
    .key   (found_key),
    .pay   (found_pay)
  );

  // result of the accepted transaction
  always_comb begin
    count_nxt   = count_r;
    status_nxt  = STS_DONE;
    key_out_nxt = '0;
    pay_out_nxt = '0;
    case (in_ch.action)
      ACT_ENQ: begin
        if (full) begin
          status_nxt = STS_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      ACT_DEQ: begin
        if (empty) begin
          status_nxt = STS_EMPTY;
        end else begin
          count_nxt   = count_r - CNT_W'(1);
          key_out_nxt = keys[0];
          pay_out_nxt = pays[0];
        end
      end
      ACT_SEARCH: begin
        if (found) begin
          key_out_nxt = found_key;
          pay_out_nxt = found_pay;
        end else begin
          status_nxt = STS_NOTFOUND;
        end
      end
      default: begin
        status_nxt = STS_DONE;
      end
    endcase
  end

  // output valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (acc) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (acc) begin
        count_r <= count_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (acc) begin
      status_r  <= status_nxt;
      key_out_r <= key_out_nxt;
      pay_out_r <= pay_out_nxt;
      occ_r     <= count_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = status_r;
  assign out_ch.key_out     = key_out_r;
  assign out_ch.payload_out = pay_out_r;
  assign out_ch.occupancy   = occ_r;

endmodule

`default_nettype wire

/* dv/fqks_checker.sv */
// scoreboard for the key-search queue: mirrors the queue and checks every result transaction
`timescale 1ns / 100ps

module fqks_checker
  import fqks_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  fqks_in_if   in_mon,
  fqks_out_if  out_mon,
  output int   fail_count,
  output int   pending_count,
  output int   n_enq,
  output int   n_deq,
  output int   n_search,
  output int   n_unused,
  output int   n_full,
  output int   n_empty,
  output int   n_hit,
  output int   n_miss
);

  typedef struct packed {
    sts_t status;
    key_t key;
    pay_t pay;
    cnt_t occ;
  } reply_t;

  // mirror of the queue contents and pointers
  key_t   mirror_key [DEPTH];
  pay_t   mirror_pay [DEPTH];
  int     head_idx;
  int     tail_idx;
  int     fill;

  // replies predicted for accepted requests, oldest first
  reply_t pending_replies [$];

  function automatic int ring_next(int p);
    return (p == DEPTH - 1) ? 0 : p + 1;
  endfunction

  // apply one request to the mirror and work out the reply it causes
  function automatic reply_t queue_apply(act_t act, key_t key, pay_t pay);
    reply_t r;
    int     p;
    r = '0;
    case (act)
      ACT_ENQ: begin
        if (fill >= DEPTH) begin
          r.status = STS_FULL;
        end else begin
          mirror_key[tail_idx] = key;
          mirror_pay[tail_idx] = pay;
          tail_idx = ring_next(tail_idx);
          fill++;
        end
      end
      ACT_DEQ: begin
        if (fill == 0) begin
          r.status = STS_EMPTY;
        end else begin
          r.key = mirror_key[head_idx];
          r.pay = mirror_pay[head_idx];
          head_idx = ring_next(head_idx);
          fill--;
        end
      end
      ACT_SEARCH: begin
        // walk oldest to newest so the newest match is the one kept
        r.status = STS_NOTFOUND;
        p = head_idx;
        for (int i = 0; i < fill; i++) begin
          if (mirror_key[p] == key) begin
            r.status = STS_DONE;
            r.key = mirror_key[p];
            r.pay = mirror_pay[p];
          end
          p = ring_next(p);
        end
      end
      default: begin
      end
    endcase
    r.occ = cnt_t'(fill);
    return r;
  endfunction

  task automatic flag_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected 'h%0h, got 'h%0h", $time, name, want, got);
    end
  endtask

  // watch both channels on every edge
  always @(posedge clk) begin
    reply_t want;
    reply_t made;
    if (!rst_n) begin
      head_idx = 0;
      tail_idx = 0;
      fill = 0;
      pending_replies.delete();
    end else begin
      // result transaction: compare with the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        if (pending_replies.size() == 0) begin
          fail_count++;
          $display("%0t: result with nothing expected, status %0d key 'h%0h payload 'h%0h",
                   $time, out_mon.status, out_mon.key_out, out_mon.payload_out);
        end else begin
          want = pending_replies.pop_front();
          flag_field("status", 32'(want.status), 32'(out_mon.status));
          flag_field("key_out", 32'(want.key), 32'(out_mon.key_out));
          flag_field("payload_out", want.pay, out_mon.payload_out);
          flag_field("occupancy", 32'(want.occ), 32'(out_mon.occupancy));
        end
      end
      // request transaction: predict and tally
      if (in_mon.valid && in_mon.ready) begin
        made = queue_apply(in_mon.action, in_mon.key, in_mon.payload);
        pending_replies.push_back(made);
        case (in_mon.action)
          ACT_ENQ: begin
            n_enq++;
            if (made.status == STS_FULL) n_full++;
          end
          ACT_DEQ: begin
            n_deq++;
            if (made.status == STS_EMPTY) n_empty++;
          end
          ACT_SEARCH: begin
            n_search++;
            if (made.status == STS_DONE) n_hit++;
            else n_miss++;
          end
          default: begin
            n_unused++;
          end
        endcase
      end
    end
    pending_count <= pending_replies.size();
  end

endmodule

/* dv/testbench.sv */
// clock, reset and request/result traffic for the key-search queue, with the verdict
`timescale 1ns / 100ps

module testbench;
  import fqks_pkg::*;

  localparam act_t ACT_UNUSED   = 2'd3;
  localparam int   RANDOM_ITEMS = 1950;
  localparam int   IDLE_LIMIT   = 2000;
  localparam int   LONG_HOLD    = 96;
  localparam key_t KEY_MAX      = {KEY_W{1'b1}};
  localparam key_t KEY_DUP      = 31'h05A5_A5A5;

  logic clk;
  logic rst_n;

  fqks_in_if  in_ch ();
  fqks_out_if out_ch ();

  int   fail_count;
  int   pending_count;
  int   n_enq, n_deq, n_search, n_unused, n_full, n_empty, n_hit, n_miss;
  int   idle_cycles = 0;
  int   send_run = 0;
  int   recv_run = 0;
  int   taken = 0;
  key_t recent_keys [8];

  fifo_queue_with_key_search dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  fqks_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .n_enq         (n_enq),
    .n_deq         (n_deq),
    .n_search      (n_search),
    .n_unused      (n_unused),
    .n_full        (n_full),
    .n_empty       (n_empty),
    .n_hit         (n_hit),
    .n_miss        (n_miss)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // idle count per transaction, with occasional runs of back-to-back traffic
  function automatic int draw_gap(inout int run);
    if (run > 0) begin
      run--;
      return 0;
    end
    if ($urandom_range(0, 11) == 0) begin
      run = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 14);
  endfunction

  // keys: small pool for collisions, extremes, recently stored keys, full range
  function automatic key_t pick_key(bit for_search);
    int r;
    r = $urandom_range(0, 99);
    if (for_search && r < 45) return recent_keys[$urandom_range(0, 7)];
    if (r < 60) return key_t'($urandom_range(0, 7));
    if (r < 72) begin
      case ($urandom_range(0, 3))
        0: return '0;
        1: return KEY_MAX;
        2: return key_t'(31'h4000_0000);
        default: return KEY_MAX - 1;
      endcase
    end
    return key_t'($urandom);
  endfunction

  function automatic pay_t pick_payload();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    return pay_t'($urandom);
  endfunction

  // offer one request transaction and hold it until accepted
  task automatic send_item(act_t act, key_t key, pay_t pay, bit no_gap);
    int gap;
    gap = no_gap ? 0 : draw_gap(send_run);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.action  <= act;
    in_ch.key     <= key;
    in_ch.payload <= pay;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    if (act == ACT_ENQ) recent_keys[$urandom_range(0, 7)] = key;
  endtask

  // stop offering until every predicted result has been taken
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  // result side: random hold-offs, two long stalls so the block backs up
  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      gap = (taken == 400 || taken == 1400) ? LONG_HOLD : draw_gap(recv_run);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      taken++;
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // request side: reset, directed cases, random traffic, verdict
  initial begin
    int   n;
    int   r;
    int   phase_left;
    bit   fill_bias;
    bit   flood;
    act_t act;
    key_t key;
    pay_t pay;

    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.action  <= ACT_ENQ;
    in_ch.key     <= '0;
    in_ch.payload <= '0;
    foreach (recent_keys[j]) recent_keys[j] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // empty queue: dequeue, search and the unused code
    send_item(ACT_DEQ, '0, '0, 1'b0);
    send_item(ACT_SEARCH, KEY_MAX, '0, 1'b0);
    send_item(ACT_UNUSED, KEY_MAX, '1, 1'b0);

    // fill to the brim with extreme keys and payloads and a repeated key
    for (int i = 0; i < DEPTH; i++) begin
      if (i == 0) key = '0;
      else if (i == 1) key = KEY_MAX;
      else if (i == 4 || i == 11) key = KEY_DUP;
      else key = key_t'($urandom);
      if (i == 0) pay = '0;
      else if (i == 1) pay = '1;
      else pay = pay_t'($urandom);
      send_item(ACT_ENQ, key, pay, 1'b0);
    end

    // full queue: rejected enqueue, newest duplicate wins, key zero, all-ones key, miss, unused code, two dequeues
    send_item(ACT_ENQ, key_t'(1), pay_t'(1), 1'b0);
    send_item(ACT_SEARCH, KEY_DUP, '0, 1'b0);
    send_item(ACT_SEARCH, '0, '1, 1'b0);
    send_item(ACT_SEARCH, KEY_MAX, '0, 1'b0);
    send_item(ACT_SEARCH, key_t'(31'h0123_4567), '0, 1'b0);
    send_item(ACT_UNUSED, '0, '0, 1'b0);
    send_item(ACT_DEQ, '0, '0, 1'b0);
    send_item(ACT_DEQ, '0, '0, 1'b0);
    wait_drained();

    // random traffic alternating between filling and draining phases
    n = 0;
    phase_left = 0;
    fill_bias = 1'b0;
    while (n < RANDOM_ITEMS) begin
      if (phase_left == 0) begin
        fill_bias = !fill_bias;
        phase_left = $urandom_range(20, 60);
      end
      phase_left--;
      r = $urandom_range(0, 99);
      if (r < 3) act = ACT_UNUSED;
      else if (r < 28) act = ACT_SEARCH;
      else if (r < (fill_bias ? 83 : 43)) act = ACT_ENQ;
      else act = ACT_DEQ;
      key = pick_key(act == ACT_SEARCH);
      pay = pick_payload();
      // keep offering back to back around the long result stalls
      flood = (n >= 390 && n < 520) || (n >= 1390 && n < 1520);
      send_item(act, key, pay, flood);
      if (act != ACT_UNUSED) begin
        n++;
        if (n == 1000) wait_drained();
      end
    end

    wait_drained();
    repeat (4) @(posedge clk);

    $display("covered %0d enqueues (%0d refused as full), %0d dequeues (%0d on empty)",
             n_enq, n_full, n_deq, n_empty);
    $display("and %0d searches (%0d found, %0d not found), %0d items with the unused code",
             n_search, n_hit, n_miss, n_unused);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
